### hw/rtl/sprp_pkg.sv
// Shared types and constants for the slot pool allocator.
// Field widths, operation and status codes, FSM states, pick result struct.
// No dependencies.
package sprp_pkg;

	localparam int unsigned SLOT_COUNT_DEF = 32;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	localparam int unsigned IDX_MAX_W = 8;
	localparam int unsigned CNT_MAX_W = 9;
	localparam int unsigned WIDE_W    = 64;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned SLOT_W    = 5;
	localparam int unsigned FILL_W    = 6;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned S_DATA_W  = 40;
	localparam int unsigned M_DATA_W  = 48;
	localparam int unsigned START_CNT = 32;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_GET = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef struct packed {
		logic                 free_hit;
		logic [IDX_MAX_W-1:0] free_idx;
		logic                 occ_hit;
		logic [IDX_MAX_W-1:0] occ_idx;
	} pick_t;

endpackage

### hw/rtl/sprp_pick.sv
// Slot selection: lowest free slot and first occupied slot at or after a
// start slot, wrapping around. Combinational priority encoders.
// Depends on sprp_pkg.
module sprp_pick #(
	parameter int unsigned SLOT_COUNT = sprp_pkg::SLOT_COUNT_DEF,
	localparam int unsigned IdxW = $clog2(SLOT_COUNT)
) (
	input  logic [SLOT_COUNT-1:0] valid,
	input  logic [IdxW-1:0]       start,
	output sprp_pkg::pick_t       pick
);
	import sprp_pkg::*;

	logic [SLOT_COUNT-1:0] upper;

	always_comb begin
		for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
			upper[i] = valid[i] && (IdxW'(i) >= start);
		end
	end

	always_comb begin
		pick = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!valid[i]) begin
				pick.free_hit = 1'b1;
				pick.free_idx = IDX_MAX_W'(i);
			end
			if (valid[i]) begin
				pick.occ_hit = 1'b1;
				pick.occ_idx = IDX_MAX_W'(i);
			end
		end
		// prefer the first hit at or above the start slot
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (upper[i]) begin
				pick.occ_idx = IDX_MAX_W'(i);
			end
		end
	end

endmodule

### hw/rtl/slot_pool_random_pick.sv
// Slot pool allocator top level: valid bits and fill count in flops,
// slot data in a synchronous memory.
// Depends on sprp_pkg and sprp_pick.
//
//   channel | dir | tdata (low bit up)                      | tuser
//   s       | in  | item_value, start_slot                  | operation
//   m       | out | result_value, slot_used, fill_count     | status
//
// An add result goes straight to the result register on accept; a get first
// passes through the S_READ state, the read of the slot data memory.
// Reset clears the valid bits and the count at once; no clearing pass.
// The input is taken in the idle state while the result register is empty or being drained.
// A held result stalls the input side only.
module slot_pool_random_pick #(
	parameter int unsigned SLOT_COUNT = sprp_pkg::SLOT_COUNT_DEF,
	parameter int unsigned DATA_WIDTH = sprp_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// item_value[31:0], start_slot[36:32], zero fill
	input  logic [sprp_pkg::S_DATA_W-1:0] s_tdata,
	// operation[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_value[31:0], slot_used[36:32], fill_count[42:37], zero fill
	output logic [sprp_pkg::M_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [sprp_pkg::STATUS_W-1:0] m_tuser
);
	import sprp_pkg::*;

	localparam int unsigned IdxW = $clog2(SLOT_COUNT);
	localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);

	state_t state_q, state_d;

	logic [SLOT_COUNT-1:0] valid_q;
	logic [CntW-1:0]       cnt_q;

	logic [DATA_WIDTH-1:0] mem [SLOT_COUNT];
	logic [DATA_WIDTH-1:0] rd_data_q;

	logic           out_valid_q;
	status_t        out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [FILL_W-1:0] out_fill_q;
	logic           out_hasval_q;

	logic [IdxW-1:0] mod_tab [START_CNT];
	logic [IdxW-1:0] start_idx;
	pick_t           pick;

	op_t             op;
	logic [VALUE_W-1:0] in_value;
	logic [SLOT_W-1:0]  in_start;
	logic            accept;
	logic            out_free;
	logic            add_ok;
	logic            get_ok;
	logic [IdxW-1:0] free_idx;
	logic [IdxW-1:0] occ_idx;
	logic [CntW-1:0] cnt_next;
	logic [CNT_MAX_W-1:0] cnt_wide;
	logic [WIDE_W-1:0]    in_wide;
	logic [WIDE_W-1:0]    rd_wide;
	logic            load_out;

	assign op       = op_t'(s_tuser);
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_start = s_tdata[VALUE_W+SLOT_W-1:VALUE_W];

	for (genvar v = 0; v < START_CNT; v++) begin : g_mod
		localparam int unsigned ModV = v % SLOT_COUNT;
		assign mod_tab[v] = IdxW'(ModV);
	end

	assign start_idx = mod_tab[in_start];

	sprp_pick #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_pick (
		.valid(valid_q),
		.start(start_idx),
		.pick (pick)
	);

	assign free_idx = pick.free_idx[IdxW-1:0];
	assign occ_idx  = pick.occ_idx[IdxW-1:0];
	assign out_free = !out_valid_q || m_tready;
	assign add_ok   = accept && (op == OP_ADD) && pick.free_hit;
	assign get_ok   = accept && (op == OP_GET) && pick.occ_hit;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = out_free;
				accept   = s_tvalid && out_free;
				if (accept && op == OP_GET) begin
					state_d = S_READ;
				end else if (accept) begin
					load_out = 1'b1;
				end
			end
			S_READ: begin
				load_out = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		if (add_ok) begin
			cnt_next = cnt_q + CntW'(1);
		end else if (get_ok) begin
			cnt_next = cnt_q - CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (add_ok) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (get_ok) begin
				valid_q[occ_idx] <= 1'b0;
			end
			cnt_q <= cnt_next;
		end
	end

	always_comb begin
		in_wide = '0;
		in_wide[VALUE_W-1:0] = in_value;
	end

	always_ff @(posedge clk) begin
		if (add_ok) begin
			mem[free_idx] <= in_wide[DATA_WIDTH-1:0];
		end
		if (get_ok) begin
			rd_data_q <= mem[occ_idx];
		end
	end

	always_comb begin
		cnt_wide = '0;
		cnt_wide[CntW-1:0] = cnt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_fill_q   <= cnt_wide[FILL_W-1:0];
			out_hasval_q <= get_ok;
			priority if (add_ok) begin
				out_status_q <= ST_OK;
				out_slot_q   <= pick.free_idx[SLOT_W-1:0];
			end else if (get_ok) begin
				out_status_q <= ST_OK;
				out_slot_q   <= pick.occ_idx[SLOT_W-1:0];
			end else if (op == OP_ADD) begin
				out_status_q <= ST_FULL;
				out_slot_q   <= '0;
			end else begin
				out_status_q <= ST_EMPTY;
				out_slot_q   <= '0;
			end
		end
	end

	always_comb begin
		rd_wide = '0;
		if (out_hasval_q) begin
			rd_wide[DATA_WIDTH-1:0] = rd_data_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {
		(M_DATA_W - VALUE_W - SLOT_W - FILL_W)'(0),
		out_fill_q,
		out_slot_q,
		rd_wide[VALUE_W-1:0]
	};

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CntW'($countones(valid_q)))
		else $error("fill count disagrees with valid bits");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !m_tvalid)
		else $error("result word present while slot data read pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> m_tvalid && state_q == S_IDLE)
		else $error("get result not presented after data read");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[VALUE_W+SLOT_W+FILL_W-1:VALUE_W] == '0)
		else $error("empty status with nonzero slot or fill count");

endmodule
